// ===== design/dst_pkg.sv =====
// shared types, codes and constants for the dark sigma threshold block
// no dependencies
package dst_pkg;

  localparam int NUM_PIXELS_DEF = 65536;
  localparam int IDX_SPAN       = 65536;
  localparam int QDEPTH         = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int DIV_W          = 64;
  localparam int CNT_W          = 16;
  localparam int ROOT_STEPS     = 32;

  localparam logic [15:0] PIX_OFFSET = 16'd1024;
  localparam logic [15:0] K_RESET    = 16'd768;
  localparam logic [15:0] FRAMES_RESET = 16'd1;
  localparam logic [23:0] MAX24      = 24'hFFFFFF;
  localparam logic [15:0] MAX16      = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_THRESH_MULT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTRACT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW        = 3'd4;

  typedef enum logic [1:0] {
    OP_PROCESS,
    OP_FINALIZE,
    OP_RECALC,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    VIEW_PIXEL,
    VIEW_MEAN,
    VIEW_STD,
    VIEW_THRESH
  } view_t;

  typedef struct packed {
    op_t         op;
    logic        ok;
    logic [15:0] idx;
    logic [15:0] pix;
  } cmd_t;

  typedef struct packed {
    logic [15:0] k;
    logic [15:0] count;
    logic        accum;
    logic        subtract;
    view_t       view;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sum;
    logic [47:0] sq;
    logic [23:0] mean;
    logic [23:0] std;
    logic [15:0] thr;
  } ent_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_DIV,
    FS_MSQ,
    FS_VAR,
    FS_SQRT,
    FS_MUL,
    FS_DONE
  } fin_state_t;

endpackage

// ===== design/dst_front.sv =====
// front end: config registers, input accept and item classification
// depends on dst_pkg
module dst_front import dst_pkg::*; #(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic [15:0]          in_pixel_index,
  input  logic [15:0]          in_pixel_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 init_busy,
  input  logic                 push_ready,
  output logic                 push_valid,
  output cmd_t                 push_cmd,
  output cfg_t                 cfg
);

  localparam int DEPTH = (NUM_PIXELS > IDX_SPAN) ? IDX_SPAN : NUM_PIXELS;

  logic [15:0] k_r;
  logic [15:0] count_r;
  logic        accum_r;
  logic        subtract_r;
  view_t       view_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= K_RESET;
      count_r    <= FRAMES_RESET;
      accum_r    <= 1'b0;
      subtract_r <= 1'b0;
      view_r     <= VIEW_PIXEL;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESH_MULT: k_r        <= cfg_data;
        REG_FRAME_COUNT: count_r    <= cfg_data;
        REG_ACCUM:       accum_r    <= cfg_data[0];
        REG_SUBTRACT:    subtract_r <= cfg_data[0];
        REG_VIEW:        view_r     <= view_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg.k        = k_r;
    // a zero frame count divides as one
    cfg.count    = (count_r == 16'd0) ? FRAMES_RESET : count_r;
    cfg.accum    = accum_r;
    cfg.subtract = subtract_r;
    cfg.view     = view_r;
  end

  assign in_ready   = !init_busy && push_ready;
  assign push_valid = in_valid && !init_busy;

  always_comb begin
    push_cmd.op  = op_t'(in_operation);
    push_cmd.ok  = ({16'd0, in_pixel_index} < 32'(DEPTH));
    push_cmd.idx = in_pixel_index;
    push_cmd.pix = in_pixel_value;
  end

endmodule

// ===== design/dst_queue.sv =====
// short command queue between front and back end
// depends on dst_pkg
module dst_queue import dst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           slot_r [QDEPTH];
  logic [QAW-1:0] wptr_r;
  logic [QAW-1:0] rptr_r;
  logic [QCW-1:0] cnt_r;
  logic           push;
  logic           pop;

  assign push_ready = (cnt_r != QCW'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == QAW'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == QAW'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/dst_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on dst_pkg
module dst_div import dst_pkg::*; #(
  parameter int DW = DIV_W,
  parameter int VW = CNT_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, q_r[DW-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= CW'(DW);
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= ge ? VW'(rem_sh - {1'b0, dvs_r}) : rem_sh[VW-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CW'(1)) begin
      busy_r <= 1'b0;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ===== design/dst_back.sv =====
// back end: pixel store, execute stage, finalize sequencer, output register
// depends on dst_pkg and dst_div
module dst_back import dst_pkg::*; #(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  input  cfg_t        cfg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_out,
  output logic [15:0] out_index_out,
  output logic        init_busy
);

  localparam int DEPTH = (NUM_PIXELS > IDX_SPAN) ? IDX_SPAN : NUM_PIXELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCW   = $clog2(ROOT_STEPS + 1);

  ent_t mem [DEPTH];
  ent_t rd_data_r;
  ent_t byp_r;
  logic hit_r;

  logic          init_r;
  logic [AW-1:0] init_cnt_r;

  logic b_valid_r;
  cmd_t b_cmd_r;

  logic        out_valid_r;
  logic [15:0] out_pixel_r;
  logic [15:0] out_index_r;

  fin_state_t state_r, state_nxt;
  logic       div_start;
  logic       fsm_done;

  logic [23:0]      mean_w_r;
  logic [23:0]      std_w_r;
  logic [DIV_W-1:0] ex2_r;
  logic [47:0]      msq_r;
  logic [63:0]      rad_r;
  logic [35:0]      rem_r;
  logic [31:0]      root_r;
  logic [SCW-1:0]   sq_cnt_r;
  logic [39:0]      prod_r;

  logic             div0_busy, div1_busy;
  logic [DIV_W-1:0] div0_q, div1_q;

  ent_t          ent_c;
  ent_t          wr_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] addr_b;
  logic          out_free;
  logic          b_done;
  logic          pop;
  logic [31:0]   pix_sq;
  logic [40:0]   tsum;
  logic [15:0]   thr_c;
  logic [15:0]   dk;
  logic [15:0]   res;
  logic [35:0]   rem_sh;
  logic [35:0]   trial;
  logic          take;
  logic [35:0]   rem_nxt;
  logic [31:0]   root_nxt;

  // ---- execute stage entry, with forward of the write made as it was read
  assign addr_b = b_cmd_r.idx[AW-1:0];

  always_comb begin
    if (!b_cmd_r.ok)  ent_c = '0;
    else if (hit_r)   ent_c = byp_r;
    else              ent_c = rd_data_r;
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    b_done = 1'b0;
    if (b_valid_r) begin
      case (b_cmd_r.op)
        OP_PROCESS: b_done = out_free;
        OP_CLEAR:   b_done = 1'b1;
        default:    b_done = fsm_done;
      endcase
    end
  end

  assign q_ready = !init_r && (!b_valid_r || b_done);
  assign pop     = q_valid && q_ready;

  // ---- arithmetic
  assign pix_sq = b_cmd_r.pix * b_cmd_r.pix;
  assign tsum   = 41'(prod_r) + 41'({mean_w_r, 8'd0});
  assign thr_c  = (|tsum[40:32]) ? MAX16 : tsum[31:16];
  assign dk     = ent_c.mean[23:8];

  always_comb begin
    case (cfg.view)
      VIEW_MEAN:   res = ent_c.mean[23:8];
      VIEW_STD:    res = ent_c.std[23:8];
      VIEW_THRESH: res = ent_c.thr;
      default: begin
        if (cfg.subtract)
          res = (b_cmd_r.pix > ent_c.thr) ? (b_cmd_r.pix + PIX_OFFSET - dk) : 16'd0;
        else
          res = b_cmd_r.pix;
      end
    endcase
  end

  // bitwise square root step
  assign rem_sh   = {rem_r[33:0], rad_r[63:62]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign take     = (rem_sh >= trial);
  assign rem_nxt  = take ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_r[30:0], take};

  // ---- store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_b;
    wr_data = ent_c;
    if (init_r) begin
      wr_en   = 1'b1;
      wr_addr = init_cnt_r;
      wr_data = '0;
    end else begin
      case (b_cmd_r.op)
        OP_PROCESS: begin
          wr_en       = b_done && b_cmd_r.ok && cfg.accum;
          wr_data.sum = ent_c.sum + {16'd0, b_cmd_r.pix};
          wr_data.sq  = ent_c.sq + {16'd0, pix_sq};
        end
        OP_FINALIZE: begin
          wr_en        = b_done && b_cmd_r.ok;
          wr_data.mean = mean_w_r;
          wr_data.std  = std_w_r;
          wr_data.thr  = thr_c;
        end
        OP_RECALC: begin
          wr_en       = b_done && b_cmd_r.ok;
          wr_data.thr = thr_c;
        end
        default: begin
          wr_en   = b_done && b_cmd_r.ok;
          wr_data = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (pop) begin
      rd_data_r <= mem[q_cmd.idx[AW-1:0]];
      byp_r     <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (pop) begin
      hit_r <= wr_en && (wr_addr == q_cmd.idx[AW-1:0]);
    end
  end

  // ---- clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r     <= 1'b1;
      init_cnt_r <= '0;
    end else if (init_r) begin
      if (init_cnt_r == AW'(DEPTH - 1)) init_r <= 1'b0;
      else init_cnt_r <= init_cnt_r + 1'b1;
    end
  end

  assign init_busy = init_r;

  // ---- execute stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (pop) begin
      b_valid_r <= 1'b1;
    end else if (b_done) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) b_cmd_r <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_done && b_cmd_r.op == OP_PROCESS) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_done && b_cmd_r.op == OP_PROCESS) begin
      out_pixel_r <= res;
      out_index_r <= b_cmd_r.idx;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_index_out = out_index_r;

  // ---- finalize / recalc sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FS_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (b_valid_r && b_cmd_r.op == OP_FINALIZE)    state_nxt = FS_DIV;
        else if (b_valid_r && b_cmd_r.op == OP_RECALC) state_nxt = FS_MUL;
      end
      FS_DIV:  if (!div0_busy && !div1_busy) state_nxt = FS_MSQ;
      FS_MSQ:  state_nxt = FS_VAR;
      FS_VAR:  state_nxt = FS_SQRT;
      FS_SQRT: if (sq_cnt_r == SCW'(1)) state_nxt = FS_MUL;
      FS_MUL:  state_nxt = FS_DONE;
      FS_DONE: state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    fsm_done  = 1'b0;
    case (state_r)
      FS_IDLE: div_start = b_valid_r && b_cmd_r.op == OP_FINALIZE;
      FS_DONE: fsm_done  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      FS_IDLE: begin
        if (b_valid_r && b_cmd_r.op == OP_RECALC) begin
          mean_w_r <= ent_c.mean;
          std_w_r  <= ent_c.std;
        end
      end
      FS_DIV: begin
        if (!div0_busy && !div1_busy) begin
          mean_w_r <= (|div0_q[DIV_W-1:24]) ? MAX24 : div0_q[23:0];
          ex2_r    <= div1_q;
        end
      end
      FS_MSQ: msq_r <= mean_w_r * mean_w_r;
      FS_VAR: begin
        rad_r    <= (ex2_r > {16'd0, msq_r}) ? (ex2_r - {16'd0, msq_r}) : '0;
        rem_r    <= '0;
        root_r   <= '0;
        sq_cnt_r <= SCW'(ROOT_STEPS);
      end
      FS_SQRT: begin
        rad_r    <= {rad_r[61:0], 2'b00};
        rem_r    <= rem_nxt;
        root_r   <= root_nxt;
        sq_cnt_r <= sq_cnt_r - 1'b1;
        if (sq_cnt_r == SCW'(1))
          std_w_r <= (|root_nxt[31:24]) ? MAX24 : root_nxt[23:0];
      end
      FS_MUL:  prod_r <= cfg.k * std_w_r;
      default: ;
    endcase
  end

  dst_div #(.DW(DIV_W), .VW(CNT_W)) u_div_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({24'd0, ent_c.sum, 8'd0}),
    .divisor  (cfg.count),
    .busy     (div0_busy),
    .quotient (div0_q)
  );

  dst_div #(.DW(DIV_W), .VW(CNT_W)) u_div_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({ent_c.sq, 16'd0}),
    .divisor  (cfg.count),
    .busy     (div1_busy),
    .quotient (div1_q)
  );

  // ---- checks
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !pop) else $error("item issued during clearing pass");

  a_done_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    b_done |-> b_valid_r) else $error("execute stage retired nothing");

  a_out_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (b_done && b_cmd_r.op == OP_PROCESS && out_valid_r) |-> out_ready)
    else $error("output register overwritten");

  a_div_idle_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FS_SQRT) |-> (!div0_busy && !div1_busy))
    else $error("divider busy during root");

  // the last sequencer cycle retires the item, so the next one may pop then
  a_seq_only_busy_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != FS_IDLE && state_r != FS_DONE) |-> (b_valid_r && !pop))
    else $error("sequencer running without a held item");

endmodule

// ===== design/dark_sigma_threshold_subtract.sv =====
// top level of the dark sigma threshold subtract block
// depends on dst_pkg, dst_front, dst_queue, dst_back
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_operation, in_pixel_index, in_pixel_value
//  out     | output    | out_valid / out_ready | out_pixel_out, out_index_out
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// process and clear beats retire one per cycle, a process beat only while the output
//   is not stalled; a process result passes the queue, the store read and the output register
// recalc in the execute stage reads the stored mean and std, does one 16x24 multiply, then the add
// finalize runs the 64-step divider pair, then the mean square and variance, then
//   the 32-step square root and the threshold multiply and add
// after reset a clearing pass writes zero to every store entry, one per cycle
//   (NUM_PIXELS entries, at most 65536), and in_ready stays low meanwhile
// a stalled output holds the execute stage; the queue keeps taking input beats
//   until it fills
module dark_sigma_threshold_subtract import dst_pkg::*; #(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic [15:0]          in_pixel_index,
  input  logic [15:0]          in_pixel_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_pixel_out,
  output logic [15:0]          out_index_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // front to queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  // queue to back
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;
  // live register values and clearing status
  cfg_t cfg;
  logic init_busy;

  dst_front #(.NUM_PIXELS(NUM_PIXELS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_pixel_index (in_pixel_index),
    .in_pixel_value (in_pixel_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .init_busy      (init_busy),
    .push_ready     (push_ready),
    .push_valid     (push_valid),
    .push_cmd       (push_cmd),
    .cfg            (cfg)
  );

  // decouples input acceptance from execute stalls
  dst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // store, forwarding, finalize sequencer and result register
  dst_back #(.NUM_PIXELS(NUM_PIXELS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (pop_valid),
    .q_ready       (pop_ready),
    .q_cmd         (pop_cmd),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_index_out (out_index_out),
    .init_busy     (init_busy)
  );

endmodule

// ===== sim/tb_dark_sigma_threshold_subtract.sv =====
// testbench for dark_sigma_threshold_subtract: directed table, then random phases
// depends on dst_pkg and the design top level; self-checking against its own predictor
`timescale 1ns / 1ps

module tb_dark_sigma_threshold_subtract;
  import dst_pkg::*;

  localparam int NPIX        = NUM_PIXELS_DEF;
  localparam int SETTLE      = 400;     // covers queued finalize passes
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 70;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [15:0] reg_data;
    op_t         op;
    logic [15:0] idx;
    logic [15:0] pix;
    bit          typed;      // expected pixel_out given in the row
    logic [15:0] typed_pix;
  } row_t;

  typedef struct {
    logic [15:0] pix;
    logic [15:0] idx;
  } calib_beat_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_operation;
  logic [15:0] in_pixel_index, in_pixel_value;
  logic out_valid, out_ready;
  logic [15:0] out_pixel_out, out_index_out;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  dark_sigma_threshold_subtract dut (.*);

  // predictor copy of the per-pixel stores
  bit [31:0] acc_sum   [NPIX];
  bit [47:0] acc_sq    [NPIX];
  bit [23:0] mean_q8   [NPIX];
  bit [23:0] std_q8    [NPIX];
  bit [15:0] dark_lvl  [NPIX];
  bit [15:0] thr_lvl   [NPIX];

  // predictor copy of the registers
  bit [15:0] k_q8;
  bit [15:0] frames;
  bit        accum_on;
  bit        subtract_on;
  view_t     view;

  calib_beat_t pending_pixels[$];
  row_t        rows[$];
  int          errors;
  int          cycles;
  bit          calm;       // no idling on either side
  int          hold_req;   // long receiver hold-off, picked up by the receiver
  logic [15:0] pool[8];
  logic [15:0] base_lvl[8];

  // clock: 2 ns period
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dark_sigma_threshold_subtract test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // threshold and dark level from stored mean and std
  function automatic void rebuild_threshold(input int p);
    logic [63:0] t;
    t = (64'(k_q8) * 64'(std_q8[p]) + (64'(mean_q8[p]) << 8)) >> 16;
    thr_lvl[p]  = (t > 64'hFFFF) ? 16'hFFFF : t[15:0];
    dark_lvl[p] = mean_q8[p][23:8];
  endfunction

  function automatic void finalize_pixel(input int p);
    logic [63:0] cnt, mean, sq, ex2, msq, var_q16, root, trial;
    cnt = (frames == 0) ? 64'd1 : 64'(frames);
    mean = (64'(acc_sum[p]) << 8) / cnt;
    sq = 64'(acc_sq[p]);
    ex2 = (sq / cnt) * 64'd65536 + ((sq % cnt) * 64'd65536) / cnt;
    if (mean > 64'hFFFFFF) mean = 64'hFFFFFF;
    msq = mean * mean;
    var_q16 = (ex2 > msq) ? ex2 - msq : 64'd0;
    // bitwise integer square root, 32 steps
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= var_q16) root = trial;
    end
    if (root > 64'hFFFFFF) root = 64'hFFFFFF;
    mean_q8[p] = mean[23:0];
    std_q8[p]  = root[23:0];
    rebuild_threshold(p);
  endfunction

  // advance the predictor by one input beat; queue the pixel it must return
  function automatic void predict_beat(input op_t op, input logic [15:0] idx,
                                       input logic [15:0] pix, input bit typed,
                                       input logic [15:0] typed_pix);
    int p;
    logic [15:0] res;
    p = idx;
    case (op)
      OP_FINALIZE: finalize_pixel(p);
      OP_RECALC:   rebuild_threshold(p);
      OP_CLEAR: begin
        acc_sum[p] = 0; acc_sq[p] = 0; mean_q8[p] = 0;
        std_q8[p] = 0; dark_lvl[p] = 0; thr_lvl[p] = 0;
      end
      default: begin
        if (accum_on) begin
          acc_sum[p] = acc_sum[p] + 32'(pix);
          acc_sq[p]  = acc_sq[p] + 48'(pix) * 48'(pix);
        end
        case (view)
          VIEW_MEAN:   res = mean_q8[p][23:8];
          VIEW_STD:    res = std_q8[p][23:8];
          VIEW_THRESH: res = thr_lvl[p];
          default:     res = subtract_on ? ((pix > thr_lvl[p]) ?
                                            16'(PIX_OFFSET + pix - dark_lvl[p]) : 16'd0)
                                         : pix;
        endcase
        pending_pixels.push_back('{pix: typed ? typed_pix : res, idx: idx});
      end
    endcase
  endfunction

  // offer one input beat, hold until accepted, then maybe idle
  task automatic send_beat(input op_t op, input logic [15:0] idx, input logic [15:0] pix,
                           input bit typed = 0, input logic [15:0] typed_pix = 0);
    int gap;
    in_valid = 1'b1;
    in_operation = op;
    in_pixel_index = idx;
    in_pixel_value = pix;
    do @(posedge clk); while (!in_ready);
    predict_beat(op, idx, pix, typed, typed_pix);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b0;
  endtask

  // config writes only while idle: results drained and finalize passes done
  task automatic drain;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] r, input logic [15:0] d);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_THRESH_MULT: k_q8 = d;
      REG_FRAME_COUNT: frames = d;
      REG_ACCUM:       accum_on = d[0];
      REG_SUBTRACT:    subtract_on = d[0];
      default:         view = view_t'(d[1:0]);
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_cfg(input logic [2:0] r, input logic [15:0] d);
    rows.push_back('{kind: ROW_CFG, reg_idx: r, reg_data: d, op: OP_PROCESS,
                     idx: 0, pix: 0, typed: 0, typed_pix: 0});
  endtask

  task automatic add_item(input op_t op, input logic [15:0] idx, input logic [15:0] pix,
                          input bit typed = 0, input logic [15:0] typed_pix = 0);
    rows.push_back('{kind: ROW_ITEM, reg_idx: 0, reg_data: 0, op: op, idx: idx, pix: pix,
                     typed: typed, typed_pix: typed_pix});
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_ready = 1'b0;
        hold_req--;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall = $urandom_range(0, 12);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // result checker: each beat against the oldest expectation
  always @(posedge clk) begin
    calib_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected beat", out_pixel_out, 16'h0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_out !== want.pix) report_mismatch("pixel_out", out_pixel_out, want.pix);
        if (out_index_out !== want.idx) report_mismatch("index_out", out_index_out, want.idx);
      end
    end
  end

  initial begin
    op_t op;
    int  sel, pick;
    logic [15:0] pidx, ppix;

    in_valid = 0; in_operation = 0; in_pixel_index = 0; in_pixel_value = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    errors = 0; cycles = 0; calm = 0; hold_req = 0;
    k_q8 = K_RESET; frames = FRAMES_RESET; accum_on = 0; subtract_on = 0; view = VIEW_PIXEL;

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset values, extremes, every view and operation
    add_item(OP_PROCESS, 16'd0, 16'hFFFF, 1, 16'hFFFF);   // raw pass-through
    add_item(OP_PROCESS, 16'hFFFF, 16'h0000, 1, 16'h0000);
    add_cfg(REG_VIEW, 16'(VIEW_MEAN));
    add_item(OP_PROCESS, 16'd5, 16'd7, 1, 16'd0);          // stores zero after reset
    add_cfg(REG_VIEW, 16'(VIEW_STD));
    add_item(OP_PROCESS, 16'd5, 16'd7, 1, 16'd0);
    add_cfg(REG_VIEW, 16'(VIEW_THRESH));
    add_item(OP_PROCESS, 16'd5, 16'd7, 1, 16'd0);
    add_cfg(REG_VIEW, 16'(VIEW_PIXEL));
    add_cfg(REG_SUBTRACT, 16'd1);
    add_item(OP_PROCESS, 16'd9, 16'd0, 1, 16'd0);          // not above zero threshold
    add_item(OP_PROCESS, 16'd9, 16'd1, 1, 16'd1025);
    add_item(OP_PROCESS, 16'd9, 16'hFFFF, 1, 16'd1023);    // wraps at 16 bits
    add_cfg(REG_SUBTRACT, 16'd0);
    add_cfg(REG_ACCUM, 16'd1);
    add_cfg(REG_FRAME_COUNT, 16'd0);                       // zero count acts as one
    add_item(OP_PROCESS, 16'd3, 16'd100);
    add_item(OP_PROCESS, 16'd3, 16'd300);
    add_item(OP_FINALIZE, 16'd3, 16'd0);
    add_cfg(REG_ACCUM, 16'd0);
    add_cfg(REG_THRESH_MULT, 16'hFFFF);
    add_item(OP_RECALC, 16'd3, 16'd0);
    add_cfg(REG_VIEW, 16'(VIEW_THRESH));
    add_item(OP_PROCESS, 16'd3, 16'd0);
    add_cfg(REG_VIEW, 16'(VIEW_STD));
    add_item(OP_PROCESS, 16'd3, 16'd0);
    add_cfg(REG_VIEW, 16'(VIEW_MEAN));
    add_item(OP_PROCESS, 16'd3, 16'd0);
    add_item(OP_CLEAR, 16'd3, 16'd0);
    add_item(OP_PROCESS, 16'd3, 16'd0);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(rows[i].reg_idx, rows[i].reg_data);
      end else begin
        send_beat(rows[i].op, rows[i].idx, rows[i].pix, rows[i].typed, rows[i].typed_pix);
      end
    end

    // pixel pool, the edges of the index range among them
    pool[0] = 16'd0;
    pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) pool[i] = 16'($urandom);
    for (int i = 0; i < 8; i++) base_lvl[i] = 16'($urandom_range(0, 4000));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin write_reg(REG_THRESH_MULT, 16'd0);    write_reg(REG_FRAME_COUNT, 16'hFFFF); end
        1: begin write_reg(REG_THRESH_MULT, 16'hFFFF); write_reg(REG_FRAME_COUNT, 16'd1); end
        default: begin
          write_reg(REG_THRESH_MULT, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 1536)));
          write_reg(REG_FRAME_COUNT, 16'($urandom_range(1, 24)));
        end
      endcase
      // even phases gather darks, odd ones apply them
      write_reg(REG_ACCUM, 16'(ph % 2 == 0));
      write_reg(REG_SUBTRACT, 16'(ph % 2 == 1 || $urandom_range(0, 3) == 0));
      write_reg(REG_VIEW, 16'($urandom_range(0, 3)));
      calm = (ph == PHASES - 1);
      if (ph == 4) hold_req = 300;   // block fills up and stalls its input

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 99);
        op = (sel < 72) ? OP_PROCESS : (sel < 86) ? OP_FINALIZE :
             (sel < 95) ? OP_RECALC : OP_CLEAR;
        pick = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0) begin
          pidx = 16'($urandom);
          ppix = 16'($urandom);
        end else begin
          pidx = pool[pick];
          ppix = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                 : 16'(base_lvl[pick] + $urandom_range(0, 200));
        end
        send_beat(op, pidx, ppix);
      end
    end

    // end of run: all results in, then let the block settle
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_pixels.size() != 0) errors++;
    if (errors == 0) begin
      $display("dark_sigma_threshold_subtract test passed");
    end else begin
      $display("dark_sigma_threshold_subtract test failed");
    end
    $finish;
  end

endmodule
